/* hw/rtl/d8fto_pkg.sv */
// Package for the D8 flow topological order walker.
// Holds payload structs, command and kind codes, controller types and limits.
// No dependencies.
package d8fto_pkg;

    localparam int DEF_MAX_ROWS = 256;
    localparam int DEF_MAX_COLS = 256;
    localparam int SEED_DEPTH   = 65536;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_SEED = 2'd1;
    localparam logic [1:0] CMD_STEP = 2'd2;

    localparam logic [1:0] KIND_DONOR = 2'd0;
    localparam logic [1:0] KIND_CONT  = 2'd1;
    localparam logic [1:0] KIND_FIN   = 2'd2;

    localparam logic [1:0] CFG_ROWS    = 2'd0;
    localparam logic [1:0] CFG_COLS    = 2'd1;
    localparam logic [1:0] CFG_MISSING = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] cell_index;
        logic [16:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] position;
        logic [16:0] donor;
        logic [16:0] receiver;
        logic        last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_START, ST_CHECK, ST_DIVIDE, ST_NB_ADDR, ST_NB_READ,
        ST_NB_TEST, ST_EMIT, ST_ADVANCE, ST_POP_WAIT, ST_STATUS
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;      // place pointers, fetch first seed
        logic div_start;  // begin row/column split of current cell
        logic nb_addr;    // compute neighbor address for nb_k
        logic nb_read;    // issue grid read
        logic push;       // write donor into queue, decrement write pointer
        logic nb_next;    // move to next neighbor
        logic advance;    // pop queue or take next seed
        logic pop_load;   // latch popped or seed value into current cell
        logic set_done;   // walk finished
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty_walk; // no seeds or negative start
        logic cell_ok;    // current cell valid and in grid
        logic div_busy;
        logic nb_in_grid;
        logic nb_match;   // neighbor drains here and list not full
        logic nb_last;    // neighbor index is 7
        logic finished;   // walk finishes at end of this step
        logic phase_run;
        logic phase_done;
    } dp_stat_t;

endpackage

/* hw/rtl/d8fto_datapath.sv */
// Datapath of the D8 walker: grid, seed and queue memories, pointers,
// a serial row/column divider and neighbor address logic. Uses d8fto_pkg.
module d8fto_datapath
    import d8fto_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load_we,
    input  logic [15:0] load_index,
    input  logic [16:0] load_value,
    input  logic        seed_we,
    input  logic [16:0] seed_value,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    output logic [15:0] position,
    output logic [16:0] donor,
    output logic [16:0] receiver
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int NW    = $clog2(CELLS + 1);
    localparam int QW    = NW + 1;            // signed pointer width
    localparam int SW    = $clog2(SEED_DEPTH);

    // Configuration registers.
    logic [8:0]  rows_cfg_reg, cols_cfg_reg;
    logic [16:0] missing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= 9'd256;
            cols_cfg_reg <= 9'd256;
            missing_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROWS:    rows_cfg_reg <= cfg_data[8:0];
                CFG_COLS:    cols_cfg_reg <= cfg_data[8:0];
                CFG_MISSING: missing_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective dimensions: zero acts as one, large values saturate.
    logic [RW-1:0] rows;
    logic [CW-1:0] cols;
    always_comb
    begin
        if (rows_cfg_reg == 9'd0)
            rows = RW'(1);
        else if (32'(rows_cfg_reg) > MAX_ROWS)
            rows = RW'(MAX_ROWS);
        else
            rows = RW'(rows_cfg_reg);
        if (cols_cfg_reg == 9'd0)
            cols = CW'(1);
        else if (32'(cols_cfg_reg) > MAX_COLS)
            cols = CW'(MAX_COLS);
        else
            cols = CW'(cols_cfg_reg);
    end

    logic [NW-1:0] nrc;
    assign nrc = NW'(rows * cols);

    // Receiver grid memory, write port and one registered read port.
    logic [16:0]   grid_mem [CELLS];
    logic [AW-1:0] grid_raddr;
    logic [16:0]   grid_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (load_we && 32'(load_index) < CELLS)
            grid_mem[AW'(load_index)] <= load_value;
        if (cmd.nb_read)
            grid_rdata_reg <= grid_mem[grid_raddr];
    end

    // Seed list memory.
    logic [16:0]   seed_mem [SEED_DEPTH];
    logic [SW:0]   seed_total_reg;
    logic [SW-1:0] seed_ptr_reg;
    logic [16:0]   seed_rdata_reg;
    logic [SW:0]   seed_sel;

    always_ff @(posedge clk)
    begin
        if (seed_we && !seed_total_reg[SW])
            seed_mem[seed_total_reg[SW-1:0]] <= seed_value;
        seed_rdata_reg <= seed_mem[seed_sel[SW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_total_reg <= '0;
        else if (seed_we && !seed_total_reg[SW])
            seed_total_reg <= seed_total_reg + 1'b1;
    end

    // Order queue memory.
    logic [16:0]         queue_mem [CELLS];
    logic [16:0]         queue_rdata_reg;
    logic signed [QW-1:0] wp_reg, rp_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.push)
            queue_mem[wp_reg[AW-1:0]] <= donor;
        queue_rdata_reg <= queue_mem[rp_reg[AW-1:0]];
    end

    // Walk state.
    logic [AW-1:0] cell_reg;
    logic          valid_reg;
    logic          run_reg, done_reg, fin_reg, from_queue_reg;

    logic signed [QW+1:0] start;
    assign start = $signed({2'b00, nrc}) - $signed((QW+2)'(seed_total_reg))
                 - $signed((QW+2)'(missing_reg)) - (QW+2)'(1);

    logic [SW:0] seed_ptr_inc;
    assign seed_ptr_inc = {1'b0, seed_ptr_reg} + 1'b1;

    // Seed read address: index 0 at start, else the seed after the current one.
    always_comb
    begin
        if (cmd.start)
            seed_sel = '0;
        else
            seed_sel = seed_ptr_inc;
    end

    // Serial restoring divider: cell / rows gives column, remainder row.
    logic [AW-1:0] quo_reg;
    logic [RW:0]   rem_reg;
    logic [$clog2(AW+1)-1:0] div_cnt_reg;
    logic          div_busy_reg;
    logic [RW:0]   rem_shift;

    assign rem_shift = {rem_reg[RW-1:0], quo_reg[AW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= '0;
        end
        else if (div_busy_reg)
        begin
            if (32'(div_cnt_reg) == AW - 1)
                div_busy_reg <= 1'b0;
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quo_reg <= cell_reg;
            rem_reg <= '0;
        end
        else if (div_busy_reg)
        begin
            if (rem_shift >= {1'b0, rows})
            begin
                rem_reg <= rem_shift - {1'b0, rows};
                quo_reg <= {quo_reg[AW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[AW-2:0], 1'b0};
            end
        end
    end

    // Neighbor offsets in scan order N, NE, E, SE, S, SW, W, NW.
    logic [2:0] nb_k_reg;
    logic signed [1:0] dr, dc;
    always_comb
    begin
        unique case (nb_k_reg)
            3'd0: begin dr = -2'sd1; dc =  2'sd0; end
            3'd1: begin dr = -2'sd1; dc =  2'sd1; end
            3'd2: begin dr =  2'sd0; dc =  2'sd1; end
            3'd3: begin dr =  2'sd1; dc =  2'sd1; end
            3'd4: begin dr =  2'sd1; dc =  2'sd0; end
            3'd5: begin dr =  2'sd1; dc = -2'sd1; end
            3'd6: begin dr =  2'sd0; dc = -2'sd1; end
            default: begin dr = -2'sd1; dc = -2'sd1; end
        endcase
    end

    logic signed [RW+1:0] nr;
    logic signed [AW+1:0] nc;
    assign nr = $signed({2'b00, rem_reg[RW-1:0]}) + (RW+2)'(dr);
    assign nc = $signed({2'b00, quo_reg}) + (AW+2)'(dc);

    logic nb_in_grid;
    assign nb_in_grid = (nr >= 0) && (nr < $signed({2'b00, rows}))
                     && (nc >= 0) && (nc < $signed((AW+2)'(cols)));

    // Neighbor address register: nc * rows + nr.
    logic [AW-1:0] nb_reg;
    logic          nb_in_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.nb_addr)
        begin
            nb_in_reg <= nb_in_grid;
            nb_reg    <= AW'(nc[AW-1:0] * rows) + AW'(nr[RW-1:0]);
        end
    end
    assign grid_raddr = nb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nb_k_reg <= '0;
        else if (cmd.div_start)
            nb_k_reg <= '0;
        else if (cmd.nb_next)
            nb_k_reg <= nb_k_reg + 1'b1;
    end

    // Pointer, phase and current cell updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg         <= '0;
            rp_reg         <= '0;
            seed_ptr_reg   <= '0;
            cell_reg       <= '0;
            valid_reg      <= 1'b0;
            run_reg        <= 1'b0;
            done_reg       <= 1'b0;
            fin_reg        <= 1'b0;
            from_queue_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                wp_reg         <= QW'(start);
                rp_reg         <= QW'(start);
                seed_ptr_reg   <= '0;
                run_reg        <= 1'b1;
                from_queue_reg <= 1'b0;
            end
            if (cmd.push)
                wp_reg <= wp_reg - 1'b1;
            if (cmd.advance)
            begin
                if (wp_reg < 0)
                begin
                    fin_reg        <= 1'b1;
                    from_queue_reg <= 1'b0;
                end
                else if (wp_reg == rp_reg)
                begin
                    seed_ptr_reg   <= seed_ptr_inc[SW-1:0];
                    fin_reg        <= (seed_ptr_inc >= seed_total_reg);
                    from_queue_reg <= 1'b0;
                end
                else
                begin
                    fin_reg        <= 1'b0;
                    from_queue_reg <= 1'b1;
                    rp_reg         <= rp_reg - 1'b1;
                end
            end
            // A seed of zero or past the grid memory is not a real cell.
            if (cmd.pop_load)
            begin
                if (from_queue_reg)
                begin
                    valid_reg <= queue_rdata_reg != 17'd0;
                    cell_reg  <= AW'(queue_rdata_reg - 17'd1);
                end
                else
                begin
                    valid_reg <= (seed_rdata_reg != 17'd0)
                              && (32'(seed_rdata_reg) <= CELLS);
                    cell_reg  <= AW'(seed_rdata_reg - 17'd1);
                end
            end
            if (cmd.set_done)
                done_reg <= 1'b1;
        end
    end

    assign stat.empty_walk = (seed_total_reg == '0) || (start < 0);
    assign stat.cell_ok    = valid_reg && ({1'b0, cell_reg} < (AW+1)'(nrc));
    assign stat.div_busy   = div_busy_reg;
    assign stat.nb_in_grid = nb_in_reg;
    assign stat.nb_match   = (grid_rdata_reg == 17'({1'b0, cell_reg}) + 17'd1)
                           && (wp_reg >= 0);
    assign stat.nb_last    = (nb_k_reg == 3'd7);
    assign stat.finished   = fin_reg;
    assign stat.phase_run  = run_reg;
    assign stat.phase_done = done_reg;

    assign position = 16'(wp_reg);
    assign donor    = 17'(nb_reg) + 17'd1;
    assign receiver = 17'(cell_reg) + 17'd1;

    // The write pointer never climbs during a walk once started.
    a_wp_down: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> wp_reg == $past(wp_reg) - 1'b1)
        else $error("write pointer did not step down on push");
    a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> wp_reg >= 0)
        else $error("push with negative write pointer");
    a_rp_ge_wp: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg && wp_reg >= 0 |-> rp_reg >= wp_reg)
        else $error("read pointer below write pointer");

endmodule

/* hw/rtl/d8fto_ctrl.sv */
// Controller state machine for the D8 walker: sequences one walk step.
// Uses d8fto_pkg; drives the datapath by command struct.
module d8fto_ctrl
    import d8fto_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step_go,
    output logic      step_busy,
    input  dp_stat_t  stat,
    output dp_cmd_t   cmd,
    output logic      emit_valid,
    output logic [1:0] emit_kind,
    output logic      emit_last,
    input  logic      emit_taken
);

    ctl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        emit_valid = 1'b0;
        emit_kind  = KIND_DONOR;
        emit_last  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (step_go)
                begin
                    if (stat.phase_done)
                        state_next = ST_STATUS;
                    else if (!stat.phase_run)
                    begin
                        if (stat.empty_walk)
                        begin
                            cmd.set_done = 1'b1;
                            state_next   = ST_STATUS;
                        end
                        else
                        begin
                            cmd.start  = 1'b1;
                            state_next = ST_START;
                        end
                    end
                    else
                        state_next = ST_CHECK;
                end
            end
            ST_START:
            begin
                cmd.pop_load = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (stat.cell_ok)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_POP_WAIT;
                end
            end
            ST_DIVIDE:
            begin
                if (!stat.div_busy)
                    state_next = ST_NB_ADDR;
            end
            ST_NB_ADDR:
            begin
                cmd.nb_addr = 1'b1;
                state_next  = ST_NB_READ;
            end
            ST_NB_READ:
            begin
                cmd.nb_read = 1'b1;
                state_next  = ST_NB_TEST;
            end
            ST_NB_TEST:
            begin
                if (stat.nb_in_grid && stat.nb_match)
                    state_next = ST_EMIT;
                else
                    state_next = ST_ADVANCE;
            end
            ST_EMIT:
            begin
                emit_valid = 1'b1;
                emit_kind  = KIND_DONOR;
                if (emit_taken)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_ADVANCE;
                end
            end
            ST_ADVANCE:
            begin
                if (stat.nb_last)
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_POP_WAIT;
                end
                else
                begin
                    cmd.nb_next = 1'b1;
                    state_next  = ST_NB_ADDR;
                end
            end
            ST_POP_WAIT:
            begin
                if (stat.finished)
                    cmd.set_done = 1'b1;
                else
                    cmd.pop_load = 1'b1;
                state_next = ST_STATUS;
            end
            ST_STATUS:
            begin
                emit_valid = 1'b1;
                emit_last  = 1'b1;
                emit_kind  = stat.phase_done ? KIND_FIN : KIND_CONT;
                if (emit_taken)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign step_busy = (state_reg != ST_IDLE);

    a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step_go |-> state_reg == ST_IDLE)
        else $error("step started while busy");
    a_emit_state: assert property (@(posedge clk) disable iff (!rst_n)
        emit_valid |-> (state_reg == ST_EMIT || state_reg == ST_STATUS))
        else $error("emit outside emit states");
    a_done_fin: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_STATUS && stat.phase_done |-> emit_kind == KIND_FIN)
        else $error("finished walk reported continuing");

endmodule

/* hw/rtl/d8_flow_topological_order.sv */
// D8 flow-network topological order walker. Loads and seeds are accepted
// while no walk step is busy. A walk step is accepted, then checks the
// current cell (the first step first fetches the first seed), then splits
// it into row and column with the serial divider, then for each of the
// eight neighbors computes the address, reads the grid, tests it and
// advances, emitting a donor item on a match, and at last pops the queue or
// takes the next seed and hands over the status item; output stalls hold
// the donor and status items. A step on a cell that is not a real cell skips
// the split and the scan. The single grid read port and the serial divider
// set the length of a step. Steps are handled one at a time.
module d8_flow_topological_order
    import d8fto_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data
);

    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic        step_busy, step_go;
    logic        emit_valid, emit_last, emit_taken;
    logic [1:0]  emit_kind;
    logic [15:0] position;
    logic [16:0] donor, receiver;
    logic        accept;

    // Output register that parts the result side from the controller.
    logic      out_valid_reg;
    out_item_t out_data_reg;

    assign in_stall   = step_busy;
    assign accept     = in_valid && !in_stall;
    assign step_go    = accept && in_data.cmd == CMD_STEP;
    assign emit_taken = emit_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_taken)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Status items carry zero payload fields.
    always_ff @(posedge clk)
    begin
        if (emit_taken)
        begin
            out_data_reg.kind <= emit_kind;
            out_data_reg.last <= emit_last;
            out_data_reg.position <= emit_last ? 16'd0 : position;
            out_data_reg.donor    <= emit_last ? 17'd0 : donor;
            out_data_reg.receiver <= emit_last ? 17'd0 : receiver;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    d8fto_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_go    (step_go),
        .step_busy  (step_busy),
        .stat       (stat),
        .cmd        (cmd),
        .emit_valid (emit_valid),
        .emit_kind  (emit_kind),
        .emit_last  (emit_last),
        .emit_taken (emit_taken)
    );

    d8fto_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_we    (accept && in_data.cmd == CMD_LOAD),
        .load_index (in_data.cell_index),
        .load_value (in_data.value),
        .seed_we    (accept && in_data.cmd == CMD_SEED),
        .seed_value (in_data.value),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .stat       (stat),
        .position   (position),
        .donor      (donor),
        .receiver   (receiver)
    );

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.last == (out_data.kind != KIND_DONOR)))
        else $error("last flag disagrees with kind");
    a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step_busy |-> !emit_valid)
        else $error("result emitted while idle");

endmodule

/* verif/testbench.sv */
// Testbench for the D8 flow topological order walker: directed table, then random items.
// Each result is checked against an in-bench predictor of the walk, or against the table entry for typed rows.
// Depends on d8fto_pkg and d8_flow_topological_order.
module testbench;
    import d8fto_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {WALK_IDLE, WALK_RUN, WALK_DONE} walk_state_t;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } plan_row_t;

    localparam int PLAN_LEN = 12;
    localparam int SIDE = 16;
    localparam int RAND_PER_SHAPE = 10;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;

    // Predictor state: registers, memories and walk pointers.
    int unsigned reg_rows, reg_cols, reg_missing;
    logic [16:0] grid_mem [65536];
    logic [16:0] seed_mem [65536];
    logic [16:0] order_mem [65536];
    int          n_seeds, seed_ptr, wr_ptr, rd_ptr, cur_cell;
    bit          cur_ok;
    walk_state_t walk;

    out_item_t   pending_results[$];
    int          outlets[$];
    int          errors;
    bit          calm;
    plan_row_t   plan [PLAN_LEN];

    d8_flow_topological_order dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int clamp_dim(int unsigned v, int maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic out_item_t make_result(logic [1:0] kind, int pos, int donor,
                                              int recv, bit fin);
        out_item_t r;
        r.kind = kind;
        r.position = pos[15:0];
        r.donor = donor[16:0];
        r.receiver = recv[16:0];
        r.last = fin;
        return r;
    endfunction

    function automatic void pick_seed(int i);
        logic [16:0] v;
        v = (i < SEED_DEPTH) ? seed_mem[i] : 17'd0;
        cur_ok = (v != 0);
        cur_cell = cur_ok ? int'(v) - 1 : 0;
    endfunction

    // Advance the walk by one item and queue the results it causes.
    function automatic int walk_predict(in_item_t it);
        int rows, cols, cells, start, r, c, nr, nc, nb, n;
        int d_row [8];
        int d_col [8];
        bit fin;
        logic [16:0] v;
        d_row = '{-1, -1, 0, 1, 1, 1, 0, -1};
        d_col = '{0, 1, 1, 1, 0, -1, -1, -1};
        rows = clamp_dim(reg_rows, DEF_MAX_ROWS);
        cols = clamp_dim(reg_cols, DEF_MAX_COLS);
        cells = rows * cols;
        n = 0;
        fin = 1'b0;
        if (it.cmd == CMD_LOAD)
        begin
            grid_mem[it.cell_index] = it.value;
            return 0;
        end
        if (it.cmd == CMD_SEED)
        begin
            if (n_seeds < SEED_DEPTH)
            begin
                seed_mem[n_seeds] = it.value;
                n_seeds++;
            end
            return 0;
        end
        if (it.cmd != CMD_STEP)
            return 0;

        // The first step places both pointers at the end of the list.
        if (walk == WALK_IDLE)
        begin
            start = cells - n_seeds - int'(reg_missing) - 1;
            wr_ptr = start;
            rd_ptr = start;
            seed_ptr = 0;
            if (n_seeds == 0 || start < 0)
                walk = WALK_DONE;
            else
            begin
                pick_seed(0);
                walk = WALK_RUN;
            end
        end
        if (walk == WALK_DONE)
        begin
            pending_results.push_back(make_result(KIND_FIN, 0, 0, 0, 1'b1));
            return 1;
        end

        // Scan the eight neighbors for donors into the current cell.
        if (cur_ok && cur_cell < cells)
        begin
            r = cur_cell % rows;
            c = cur_cell / rows;
            for (int k = 0; k < 8; k++)
            begin
                nr = r + d_row[k];
                nc = c + d_col[k];
                if (nr < 0 || nr >= rows || nc < 0 || nc >= cols)
                    continue;
                nb = nc * rows + nr;
                if (grid_mem[nb] == cur_cell + 1 && wr_ptr >= 0)
                begin
                    order_mem[wr_ptr] = 17'(nb + 1);
                    pending_results.push_back(make_result(KIND_DONOR, wr_ptr, nb + 1,
                                                          cur_cell + 1, 1'b0));
                    n++;
                    wr_ptr--;
                end
            end
        end

        // Pop the next cell, or fall back to the next seed.
        if (wr_ptr < 0)
            fin = 1'b1;
        else if (wr_ptr == rd_ptr)
        begin
            seed_ptr++;
            if (seed_ptr >= n_seeds)
                fin = 1'b1;
            else
                pick_seed(seed_ptr);
        end
        else
        begin
            v = order_mem[rd_ptr];
            cur_ok = (v != 0);
            cur_cell = cur_ok ? int'(v) - 1 : 0;
            rd_ptr--;
        end
        walk = fin ? WALK_DONE : WALK_RUN;
        pending_results.push_back(make_result(fin ? KIND_FIN : KIND_CONT, 0, 0, 0, 1'b1));
        return n + 1;
    endfunction

    // Offer one item, wait for acceptance, then queue its expected results.
    task automatic send_item(in_item_t it, bit typed, out_item_t want);
        int n;
        while (!calm && $urandom_range(99) < 22)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = it;
        do
            @(posedge clk);
        while (in_stall);
        n = walk_predict(it);
        if (typed)
        begin
            repeat (n) void'(pending_results.pop_back());
            pending_results.push_back(want);
        end
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send_plain(logic [1:0] cmd, int idx, int val);
        in_item_t it;
        it.cmd = cmd;
        it.cell_index = idx[15:0];
        it.value = val[16:0];
        send_item(it, 1'b0, '0);
    endtask

    // Register write while idle, mirrored into the predictor.
    task automatic write_reg(logic [1:0] idx, int val);
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val[16:0];
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_ROWS:    reg_rows = val & 'h1FF;
            CFG_COLS:    reg_cols = val & 'h1FF;
            CFG_MISSING: reg_missing = val & 'h1FFFF;
            default:     ;
        endcase
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual %h", $time, out_data);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", want.kind, out_data.kind);
                check_field("position", want.position, out_data.position);
                check_field("donor", want.donor, out_data.donor);
                check_field("receiver", want.receiver, out_data.receiver);
                check_field("last", want.last, out_data.last);
            end
        end
    end

    // Receiver stalls at random.
    always @(negedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < 22);
    end

    // Stimulus sequence.
    initial
    begin
        int r, c, nr, nc, sel, val;
        int settings [4][2];
        in_item_t it;
        settings = '{'{16, 16}, '{0, 256}, '{511, 1}, '{8, 32}};
        errors = 0;
        calm = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_ROWS;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        reg_rows = DEF_MAX_ROWS;
        reg_cols = DEF_MAX_COLS;
        reg_missing = 0;
        n_seeds = 0;
        seed_ptr = 0;
        wr_ptr = 0;
        rd_ptr = 0;
        cur_cell = 0;
        cur_ok = 1'b0;
        walk = WALK_IDLE;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Extreme register values first, then the setting the walk starts with.
        write_reg(CFG_ROWS, 511);
        write_reg(CFG_COLS, 0);
        write_reg(CFG_MISSING, 65536);
        write_reg(CFG_ROWS, SIDE);
        write_reg(CFG_COLS, SIDE);
        write_reg(CFG_MISSING, 3);

        // Fill every cell that any later setting can reach; cell 1 is an outlet.
        for (int i = 0; i < SIDE * SIDE; i++)
        begin
            r = i % SIDE;
            c = i / SIDE;
            sel = $urandom_range(99);
            if (i == 0 || sel < 10)
            begin
                val = 0;
                if (i != 0)
                    outlets.push_back(i + 1);
            end
            else if (sel < 15)
                val = $urandom_range(17'h1FFFF);
            else
            begin
                do
                begin
                    nr = r + $urandom_range(2) - 1;
                    nc = c + $urandom_range(2) - 1;
                end
                while (nr < 0 || nr >= SIDE || nc < 0 || nc >= SIDE || (nr == r && nc == c));
                val = nc * SIDE + nr + 1;
            end
            send_plain(CMD_LOAD, i, val);
        end

        // Directed table: extremes, the unused command, bad seeds of zero and of the
        // largest value, then the first steps of the walk.
        plan[0] = '{'{CMD_LOAD, 16'hFFFF, 17'h1FFFF}, 1'b0, '0};
        plan[1] = '{'{CMD_UNUSED, 16'hFFFF, 17'h1FFFF}, 1'b0, '0};
        plan[2] = '{'{CMD_SEED, 16'h0000, 17'd0}, 1'b0, '0};
        plan[3] = '{'{CMD_SEED, 16'hFFFF, 17'h1FFFF}, 1'b0, '0};
        plan[4] = '{'{CMD_SEED, 16'h0000, 17'd1}, 1'b0, '0};
        plan[5] = '{'{CMD_SEED, 16'h0000, 17'd1}, 1'b0, '0};
        plan[6] = '{'{CMD_STEP, 16'h0000, 17'd0}, 1'b1, '{KIND_CONT, 16'd0, 17'd0, 17'd0, 1'b1}};
        plan[7] = '{'{CMD_STEP, 16'hFFFF, 17'h1FFFF}, 1'b1,
                    '{KIND_CONT, 16'd0, 17'd0, 17'd0, 1'b1}};
        plan[8] = '{'{CMD_STEP, 16'h0000, 17'd0}, 1'b0, '0};
        plan[9] = '{'{CMD_UNUSED, 16'h0000, 17'd0}, 1'b0, '0};
        plan[10] = '{'{CMD_STEP, 16'h0000, 17'd0}, 1'b0, '0};
        plan[11] = '{'{CMD_STEP, 16'h0000, 17'd0}, 1'b0, '0};
        foreach (plan[i])
            send_item(plan[i].item, plan[i].typed, plan[i].want);

        // Remaining outlets join the seed list during the walk.
        foreach (outlets[i])
            send_plain(CMD_SEED, 0, outlets[i]);

        // Random part, in four grid shapes; mostly steps. The second shape
        // runs with no idling on either side.
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(CFG_ROWS, settings[ph][0]);
            write_reg(CFG_COLS, settings[ph][1]);
            write_reg(CFG_MISSING, (ph == 3) ? 65536 : $urandom_range(17'h1FFFF));
            for (int n = 0; n < RAND_PER_SHAPE; n++)
            begin
                calm = (ph == 1);
                sel = $urandom_range(99);
                it.cell_index = 16'($urandom_range(16'hFFFF));
                it.value = 17'($urandom_range(17'h1FFFF));
                if (sel < 70)
                    it.cmd = CMD_STEP;
                else if (sel < 85)
                begin
                    it.cmd = CMD_LOAD;
                    if ($urandom_range(1))
                    begin
                        it.cell_index = 16'($urandom_range(SIDE * SIDE - 1));
                        it.value = 17'($urandom_range(SIDE * SIDE));
                    end
                end
                else if (sel < 95)
                begin
                    it.cmd = CMD_SEED;
                    if ($urandom_range(1))
                        it.value = 17'($urandom_range(1, SIDE * SIDE));
                end
                else
                    it.cmd = CMD_UNUSED;
                send_item(it, 1'b0, '0);
            end
        end
        calm = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/d8fto_pkg.sv
hw/rtl/d8fto_datapath.sv
hw/rtl/d8fto_ctrl.sv
hw/rtl/d8_flow_topological_order.sv
verif/testbench.sv
